// ===== sv/dfcf_pkg.sv =====
// package: widths, constants, config register codes and types of the comb filter
`default_nettype none

package dfcf_pkg;

    localparam int LINE_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 12;
    localparam int CFG_W      = 16;
    localparam int FRAC_W     = 15;

    localparam int UNITY      = 2 ** FRAC_W;
    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);
    localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

    // signed sample times unsigned gain, then a sum of two such products
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int ACC_W      = PROD_W + 1;

    localparam int RESET_GAIN = 16384;

    typedef enum logic [1:0] {
        CFG_DELAY   = 2'd0,
        CFG_FB_GAIN = 2'd1,
        CFG_FF_GAIN = 2'd2,
        CFG_DAMPING = 2'd3
    } t_cfg_idx;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clear;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== sv/dfcf_if.sv =====
// stream interfaces: input sample channel and output sample channel
`default_nettype none

interface dfcf_in_if;
    import dfcf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface dfcf_out_if;
    import dfcf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== sv/dfcf_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module dfcf_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 24,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/dfcf_mac.sv =====
// shared multiply-accumulate unit with q15 rounding and 24-bit saturation
`default_nettype none

module dfcf_mac (
    input  wire logic               i_clk,
    input  wire dfcf_pkg::t_mac_ctl i_ctl,
    input  wire dfcf_pkg::t_sample  i_a,
    input  wire dfcf_pkg::t_gain    i_b,
    output dfcf_pkg::t_sample       o_result
);
    import dfcf_pkg::*;

    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'(SAMPLE_MAX);
    localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(SAMPLE_MIN);
    localparam logic signed [ACC_W:0] HALF   = (ACC_W + 1)'(ROUND_HALF);

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W:0]    biased;
    logic signed [ACC_W:0]    scaled;

    assign prod  = PROD_W'(i_a * $signed({1'b0, i_b}));
    assign n_acc = (i_ctl.clear ? ACC_W'(0) : r_acc) + ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    // floor((acc + half) / 2^15), then clip to the sample range
    assign biased = (ACC_W + 1)'(r_acc) + HALF;
    assign scaled = biased >>> FRAC_W;

    always_comb begin
        priority if (scaled > SAT_HI) begin
            o_result = t_sample'(SAMPLE_MAX);
        end else if (scaled < SAT_LO) begin
            o_result = t_sample'(SAMPLE_MIN);
        end else begin
            o_result = SAMPLE_W'(scaled);
        end
    end

endmodule

`default_nettype wire

// ===== sv/damped_feedback_comb_filter.sv =====
// top level: damped feedback comb filter with sequencer, delay line and shared mac
// the result is registered in step m6, which waits there while an older result is not taken
// one sample at a time: input ready only in idle, six products through one shared multiplier
// the output register lets the next input transaction in while a result waits
// reset: synchronous, active low; the delay line is then cleared one entry per cycle,
// all LINE_DEPTH (4096) entries, with input ready low; config writes are taken meanwhile
`default_nettype none

module damped_feedback_comb_filter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire dfcf_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [dfcf_pkg::CFG_W-1:0] i_cfg_data,
    dfcf_in_if.sink                 i_sample,
    dfcf_out_if.source              o_sample
);
    import dfcf_pkg::*;

    // one state per mac step; idle waits for a sample
    typedef enum logic [2:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_DEPTH - 1);
    localparam t_gain             GAIN_ONE  = GAIN_W'(UNITY);

    // control and config registers
    t_state             r_state;
    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  r_wp;
    logic               r_out_valid;
    logic [DELAY_W-1:0] r_delay;
    t_gain              r_fb_gain;
    t_gain              r_ff_gain;
    t_gain              r_damping;
    t_sample            r_lp;

    // payload registers
    t_sample            r_x;
    t_sample            r_out;

    logic               in_accept;
    logic               out_take;
    t_gain              fb;
    t_gain              ff;
    t_gain              dm;
    logic [31:0]        delay_ext;
    logic [31:0]        delay_clamp;
    logic [ADDR_W-1:0]  delay_c;
    logic [ADDR_W-1:0]  rp;
    logic [ADDR_W-1:0]  wp_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_wr_addr;
    t_sample            ram_wr_data;
    t_sample            delayed;

    t_mac_ctl           mac_ctl;
    t_sample            mac_a;
    t_gain              mac_b;
    t_sample            mac_res;

    assign i_sample.ready    = (r_state == S_IDLE) && !r_clr_busy;
    assign in_accept         = i_sample.valid && i_sample.ready;
    assign o_sample.valid    = r_out_valid;
    assign o_sample.sample_out = r_out;
    assign out_take          = r_out_valid && o_sample.ready;

    // gains above unity act as unity
    assign fb = (r_fb_gain > GAIN_ONE) ? GAIN_ONE : r_fb_gain;
    assign ff = (r_ff_gain > GAIN_ONE) ? GAIN_ONE : r_ff_gain;
    assign dm = (r_damping > GAIN_ONE) ? GAIN_ONE : r_damping;

    // read pointer: delay clamped to depth minus one, zero delay reads the oldest entry
    assign delay_ext   = 32'(r_delay);
    assign delay_clamp = (delay_ext > 32'(LINE_DEPTH - 1)) ? 32'(LINE_DEPTH - 1) : delay_ext;
    assign delay_c     = delay_clamp[ADDR_W-1:0];
    assign rp          = (r_wp >= delay_c) ? (r_wp - delay_c)
                                           : ADDR_W'(32'(r_wp) + 32'(LINE_DEPTH) - delay_clamp);
    assign wp_next     = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;

    // delay line write: clearing pass after reset, else the feedback value in step m4
    always_comb begin
        if (r_clr_busy) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else begin
            ram_we      = (r_state == S_M4);
            ram_wr_addr = r_wp;
            ram_wr_data = mac_res;
        end
    end

    dfcf_ram #(
        .DEPTH  (LINE_DEPTH),
        .WIDTH  (SAMPLE_W),
        .ADDR_W (ADDR_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rp),
        .o_rd_data (delayed)
    );

    // mac schedule, each pair of steps builds one sum of two products:
    //   m0,m1: delayed*(1-dm) + lp*dm          -> new lowpass, taken in m2
    //   m2,m3: x*1.0 + lp*fb                   -> stored value, written in m4
    //   m4,m5: x*ff + delayed*fb               -> result, taken in m6
    // the read data holds from the accept until the next accept
    always_comb begin
        mac_ctl = '{en: 1'b0, clear: 1'b0};
        mac_a   = r_x;
        mac_b   = ff;
        unique case (r_state)
            S_M0: begin
                mac_ctl = '{en: 1'b1, clear: 1'b1};
                mac_a   = delayed;
                mac_b   = GAIN_ONE - dm;
            end
            S_M1: begin
                mac_ctl = '{en: 1'b1, clear: 1'b0};
                mac_a   = r_lp;
                mac_b   = dm;
            end
            S_M2: begin
                mac_ctl = '{en: 1'b1, clear: 1'b1};
                mac_a   = r_x;
                mac_b   = GAIN_ONE;
            end
            S_M3: begin
                mac_ctl = '{en: 1'b1, clear: 1'b0};
                mac_a   = r_lp;
                mac_b   = fb;
            end
            S_M4: begin
                mac_ctl = '{en: 1'b1, clear: 1'b1};
                mac_a   = r_x;
                mac_b   = ff;
            end
            S_M5: begin
                mac_ctl = '{en: 1'b1, clear: 1'b0};
                mac_a   = delayed;
                mac_b   = fb;
            end
            S_IDLE, S_M6: begin
                mac_ctl = '{en: 1'b0, clear: 1'b0};
            end
            default: begin
                mac_ctl = '{en: 1'b0, clear: 1'b0};
            end
        endcase
    end

    dfcf_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .o_result (mac_res)
    );

    // sequencer, config registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_lp        <= '0;
            r_out_valid <= 1'b0;
            r_delay     <= '0;
            r_fb_gain   <= GAIN_W'(RESET_GAIN);
            r_ff_gain   <= GAIN_W'(RESET_GAIN);
            r_damping   <= GAIN_W'(RESET_GAIN);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DELAY:   r_delay   <= i_cfg_data[DELAY_W-1:0];
                    CFG_FB_GAIN: r_fb_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_FF_GAIN: r_ff_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_DAMPING: r_damping <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            // clearing pass over the delay line
            if (r_clr_busy) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            // in m6 a taken result is replaced by the new one below
            if (out_take && r_state != S_M6) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_x     <= i_sample.sample_in;
                        r_state <= S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_lp    <= mac_res;
                    r_state <= S_M3;
                end
                S_M3: r_state <= S_M4;
                S_M4: begin
                    r_wp    <= wp_next;
                    r_state <= S_M5;
                end
                S_M5: r_state <= S_M6;
                S_M6: begin
                    // wait here while an older result is still not taken
                    if (!r_out_valid || out_take) begin
                        r_out       <= mac_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no sample is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_accept)
        else $error("input transaction during delay line clear");

    // the delay line is written only by the clearing pass or the store step
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_clr_busy || r_state == S_M4))
        else $error("unexpected delay line write");

    // a new result appears only at the end of the sequence
    a_result_from_m6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_M6)
        else $error("result valid outside final step");

    // an accepted sample starts the mac sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_M0)
        else $error("accepted sample did not start the sequence");

    // the write pointer moves once per sample, in the store step
    a_wp_moves_in_m4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_M4) |=> $stable(r_wp))
        else $error("write pointer moved outside store step");

endmodule

`default_nettype wire

// ===== sim/damped_feedback_comb_filter_test.sv =====
// testbench: damped feedback comb filter checked sample by sample against a behavioral predictor
`timescale 1ns / 100ps

module damped_feedback_comb_filter_test;
    import dfcf_pkg::*;

    // generous bound: ~1250 samples with their gaps and stalls, plus the line clear
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRINT_CAP     = 40;
    // cycles the output is held off while the input keeps offering samples
    localparam int HOLD_CYCLES   = 200;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    dfcf_in_if  in_ch ();
    dfcf_out_if out_ch ();

    damped_feedback_comb_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (in_ch),
        .o_sample   (out_ch)
    );

    // predictor state: its own delay line, pointer, lowpass and register copies
    t_sample            echo_line [LINE_DEPTH];
    int unsigned        wr_ptr;
    t_sample            damped_level;
    logic [DELAY_W-1:0] lag_setting;
    t_gain              fb_setting;
    t_gain              ff_setting;
    t_gain              damp_setting;

    // filtered samples still owed by the block, oldest first
    t_sample awaited_outputs [$];

    int          error_count     = 0;
    int          samples_sent    = 0;
    int          samples_checked = 0;
    int          settings_used   = 0;
    int          long_holds      = 0;
    int          cycle_count     = 0;

    // knobs shared between the test tasks, the sender and the receiver
    int unsigned hold_request  = 0;
    int unsigned burst_left    = 0;
    int unsigned max_gap       = 0;
    bit          stall_enabled = 0;

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples still owed", cycle_count,
                     awaited_outputs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_sample clip24(input longint v);
        if (v > SAMPLE_MAX) return t_sample'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return t_sample'(SAMPLE_MIN);
        return t_sample'(v);
    endfunction

    // scale by 2^-15, rounding half toward plus infinity
    function automatic longint q15_round(input longint v);
        return (v + ROUND_HALF) >>> FRAC_W;
    endfunction

    // gain registers above 1.0 act as 1.0
    function automatic longint unity_clamp(input t_gain g);
        if (g > UNITY) return UNITY;
        return longint'(g);
    endfunction

    // one sample through the comb: read the tap, update the lowpass, write back, mix
    function automatic t_sample filter_sample(input t_sample x);
        int unsigned lag;
        int unsigned rd_ptr;
        longint      fb;
        longint      ff;
        longint      dm;
        longint      tap;
        fb  = unity_clamp(fb_setting);
        ff  = unity_clamp(ff_setting);
        dm  = unity_clamp(damp_setting);
        lag = 32'(lag_setting);
        if (lag > LINE_DEPTH - 1) lag = LINE_DEPTH - 1;
        // zero lag reads the oldest entry, before it is overwritten
        rd_ptr = (wr_ptr + LINE_DEPTH - lag) % LINE_DEPTH;
        tap    = longint'(echo_line[rd_ptr]);
        damped_level = clip24(q15_round(tap * (UNITY - dm) + longint'(damped_level) * dm));
        echo_line[wr_ptr] = clip24(longint'(x) + q15_round(longint'(damped_level) * fb));
        wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
        return clip24(q15_round(longint'(x) * ff + tap * fb));
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return t_sample'(SAMPLE_MAX);
            1:       return t_sample'(SAMPLE_MIN);
            2, 3, 4: return t_sample'(int'($urandom_range(0, 65535)) - 32768);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_gain pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return t_gain'(UNITY);
            2:       return t_gain'($urandom_range(UNITY + 1, 2 ** GAIN_W - 1));
            default: return t_gain'($urandom_range(0, UNITY));
        endcase
    endfunction

    // short lags are drawn often so the feedback loop actually recirculates;
    // the bits above the delay field are random and must be ignored
    function automatic logic [CFG_W-1:0] pick_lag();
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        case ($urandom_range(0, 7))
            0:       word[DELAY_W-1:0] = '0;
            1:       word[DELAY_W-1:0] = '1;
            2, 3, 4: word[DELAY_W-1:0] = DELAY_W'($urandom_range(1, 40));
            default: ;
        endcase
        return word;
    endfunction

    task automatic flag_mismatch(input string what, input t_sample got, input t_sample want);
        if (error_count < PRINT_CAP)
            $display("MISMATCH %s at output transaction %0d: got %0d, want %0d", what,
                     samples_checked, got, want);
        error_count++;
    endtask

    // all four registers back to back; only called with nothing in flight
    task automatic program_filter(input logic [CFG_W-1:0] lag_word, input t_gain fb_word,
                                  input t_gain ff_word, input t_gain damp_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DELAY;
        i_cfg_data <= lag_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FB_GAIN;
        i_cfg_data <= fb_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FF_GAIN;
        i_cfg_data <= ff_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DAMPING;
        i_cfg_data <= damp_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lag_setting  = lag_word[DELAY_W-1:0];
        fb_setting   = fb_word;
        ff_setting   = ff_word;
        damp_setting = damp_word;
        settings_used++;
    endtask

    // offer one sample; bursts of random length separated by random gaps
    task automatic send_sample(input t_sample s);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            // valid only drops when there is a real gap, never low-then-high in one step
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        // transaction taken at this edge: predict its output now
        awaited_outputs.push_back(filter_sample(s));
        burst_left--;
        samples_sent++;
    endtask

    // sender pauses until every owed output has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (awaited_outputs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver and checker

    // output ready: runs of ready with short stalls, or a long hold-off on request
    initial begin : sink_pattern
        int unsigned run_left;
        int unsigned stall_left;
        run_left   = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
                long_holds++;
            end else if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (run_left != 0) run_left--;
                if (run_left == 0) begin
                    run_left   = $urandom_range(1, 24);
                    stall_left = stall_enabled ? $urandom_range(1, 6) : 0;
                end
            end
        end
    end

    // compare every output transaction with the oldest owed sample
    always @(posedge i_clk) begin : result_check
        t_sample want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            samples_checked++;
            if (awaited_outputs.size() == 0) begin
                flag_mismatch("unexpected output", out_ch.sample_out, '0);
            end else begin
                want = awaited_outputs.pop_front();
                if (out_ch.sample_out !== want)
                    flag_mismatch("sample_out", out_ch.sample_out, want);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset registers and cleared line: zero lag reads back zeros
    task automatic test_reset_defaults();
        stall_enabled = 0;
        max_gap       = 2;
        send_sample(t_sample'(SAMPLE_MAX));
        send_sample(t_sample'(SAMPLE_MIN));
        send_sample('0);
        send_sample(t_sample'(-1));
        send_sample(t_sample'(1));
        wait_drained();
    endtask

    // unity gains, no damping, one-sample lag: output and stored value clip
    task automatic test_saturation();
        stall_enabled = 1;
        max_gap       = 3;
        program_filter(16'd1, t_gain'(UNITY), t_gain'(UNITY), '0);
        repeat (3) send_sample(t_sample'(SAMPLE_MAX));
        repeat (2) send_sample(t_sample'(SAMPLE_MIN));
        wait_drained();
    endtask

    // gains above 1.0 act as 1.0; upper bits of the delay word are dropped (lag 2)
    task automatic test_gain_clamp();
        program_filter(16'hF002, 16'hFFFF, 16'h8001, 16'hFFFF);
        send_sample(t_sample'(SAMPLE_MAX));
        send_sample(t_sample'(SAMPLE_MIN));
        send_sample(t_sample'(12345));
        send_sample(t_sample'(-777));
        send_sample(t_sample'(SAMPLE_MAX));
        wait_drained();
    endtask

    // zero gains, full damping, longest lag
    task automatic test_zero_gains();
        program_filter(16'h0FFF, '0, '0, t_gain'(UNITY));
        send_sample(t_sample'(SAMPLE_MIN));
        send_sample(t_sample'(SAMPLE_MAX));
        send_sample(t_sample'(-1));
        wait_drained();
    endtask

    // random settings per phase, random samples, varying sender and receiver pacing
    task automatic test_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_filter(pick_lag(), pick_gain(), pick_gain(), pick_gain());
            stall_enabled = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       max_gap = 0;
                1:       max_gap = 3;
                default: max_gap = 12;
            endcase
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            wait_drained();
        end
    endtask

    // output held off for a long stretch while the input keeps offering
    task automatic test_output_backpressure();
        stall_enabled = 0;
        max_gap       = 0;
        program_filter(16'd3, pick_gain(), pick_gain(), pick_gain());
        hold_request = HOLD_CYCLES;
        repeat (40) send_sample(pick_sample());
        wait_drained();
    endtask

    // a long lag against real history, then zero lag (reads the cleared entry ahead)
    // and the longest lag, whose read pointer wraps below address zero
    task automatic test_line_wraparound();
        stall_enabled = 0;
        max_gap       = 0;
        program_filter(16'd700, 16'd24000, 16'd16384, 16'd8000);
        repeat (120) send_sample(pick_sample());
        wait_drained();
        stall_enabled = 1;
        max_gap       = 2;
        program_filter(16'h0000, 16'd20000, 16'd10000, 16'd12000);
        repeat (30) send_sample(pick_sample());
        wait_drained();
        program_filter(16'hFFFF, 16'd30000, 16'd5000, 16'd2000);
        repeat (30) send_sample(pick_sample());
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin : run_tests
        for (int i = 0; i < LINE_DEPTH; i++) echo_line[i] = '0;
        wr_ptr       = 0;
        damped_level = '0;
        lag_setting  = '0;
        fb_setting   = t_gain'(RESET_GAIN);
        ff_setting   = t_gain'(RESET_GAIN);
        damp_setting = t_gain'(RESET_GAIN);

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DELAY;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its line after reset with input ready low; send waits it out
        test_reset_defaults();
        test_saturation();
        test_gain_clamp();
        test_zero_gains();
        test_random_settings();
        test_output_backpressure();
        test_line_wraparound();

        // let any stray output show up before the verdict
        repeat (16) @(posedge i_clk);

        $display("summary: %0d output samples checked over %0d filter settings (clipping, %s",
                 samples_checked, settings_used, "clamped gains, wrapped read pointer)");
        $display("summary: %0d long output hold-offs against a stalled input, %0d mismatches",
                 long_holds, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
